// File: rtl/tbw_pkg.sv
// Package: shared types, constants and helpers for the toroidal window extractor.
`timescale 1ns / 1ps
package tbw_pkg;

  localparam int SIZE_W = 9;
  localparam int DSIZE_W = 7;

  localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef struct packed {
    logic               action;
    logic [10:0]        word_index;
    logic [31:0]        word_data;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } in_t;

  typedef struct packed {
    logic [5:0]  row_index;
    logic [63:0] row_bits;
    logic        last;
  } out_t;

  typedef struct packed {
    logic wr;
    logic load;
    logic mod_step;
    logic fix;
    logic row_init;
    logic rd;
    logic merge;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic row_done;
    logic last_row;
    logic out_free;
  } sts_t;

  function automatic logic [SIZE_W-1:0] clamp9(input logic [SIZE_W-1:0] v,
                                               input logic [12:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = 9'd1;
    else if ({4'b0, v} > maxv) r = maxv[SIZE_W-1:0];
    return r;
  endfunction

  function automatic logic [DSIZE_W-1:0] clamp7(input logic [DSIZE_W-1:0] v,
                                                input logic [DSIZE_W-1:0] maxv);
    logic [DSIZE_W-1:0] r;
    r = v;
    if (v == '0) r = 7'd1;
    else if (v > maxv) r = maxv;
    return r;
  endfunction

endpackage

// File: rtl/toroidal_bitmap_window_extract.sv
// Top level of the toroidal bitmap window extractor.
// Input channel (in_valid/in_stall/in_data): a write beat stores one 32-bit
// source word at word_index (ignored beyond the memory depth) and gives no
// result. An extract beat gives a signed position; the block then returns
// dst_height row beats on the output channel (out_valid/out_stall/out_data),
// last set on the final row. For an extract, both offsets are first reduced
// (16-step restoring remainder plus sign fix), then each row takes a setup
// step, a memory read then a merge for each source word chunk, and a
// hand-over to the output register. A row has about dst_width/32 + 2 chunks
// for wide sources and up to dst_width for a source one bit wide; the single
// read port of the source memory takes them one at a time.
// in_stall is high while an extract is in progress; the next beat is taken
// once the last row sits in the output register.
// A stalled output holds its beat and the row pipeline waits for it.
// Configuration: cfg_we writes register cfg_index (0 src_width, 1 src_height,
// 2 dst_width, 3 dst_height); zero acts as one and larger values saturate;
// dst sizes use cfg_data[6:0]. Reset (rst, synchronous) empties the output
// and sets all sizes to maximum; source memory is undefined until written.
`timescale 1ns / 1ps
module toroidal_bitmap_window_extract #(
  parameter int MAX_SRC_WIDTH = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_WIDTH = 64,
  parameter int MAX_DST_HEIGHT = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tbw_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output tbw_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data
);
  import tbw_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle;

  assign in_stall = !idle;

  tbw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .idle      (idle),
    .cmd       (cmd),
    .sts       (sts)
  );

  tbw_dp #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
    .MAX_DST_WIDTH  (MAX_DST_WIDTH),
    .MAX_DST_HEIGHT (MAX_DST_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );
endmodule

// File: rtl/tbw_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module tbw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/tbw_ctrl.sv
// Controller state machine sequencing writes, offset reduction and row extraction.
`timescale 1ns / 1ps
module tbw_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          idle,
  output tbw_pkg::cmd_t cmd,
  input  tbw_pkg::sts_t sts
);
  import tbw_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MOD  = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_ROW  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_MRG  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state, state_next;
  logic [3:0] cnt;

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == ACT_EXTRACT) begin
            cmd.load = 1'b1;
            state_next = S_MOD;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (cnt == 4'd15) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        state_next = S_ROW;
      end
      S_ROW: begin
        cmd.row_init = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd = 1'b1;
        state_next = S_MRG;
      end
      S_MRG: begin
        cmd.merge = 1'b1;
        state_next = sts.row_done ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_next = sts.last_row ? S_IDLE : S_ROW;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_MOD) cnt <= cnt + 4'd1;
      else cnt <= '0;
    end
  end

`ifndef SYNTHESIS
  a_mod_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD && cnt == 4'd15) |=> state == S_FIX)
    else $error("offset reduction length wrong");
  a_emit_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !sts.out_free) |=> state == S_EMIT)
    else $error("row dropped while output full");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("conflicting datapath commands");
`endif
endmodule

// File: rtl/tbw_dp.sv
// Datapath: configuration, source memory, offset reduction and row assembly.
`timescale 1ns / 1ps
module tbw_dp #(
  parameter int MAX_SRC_WIDTH = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_DST_WIDTH = 64,
  parameter int MAX_DST_HEIGHT = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  tbw_pkg::in_t  in_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_data,
  input  tbw_pkg::cmd_t cmd,
  output tbw_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_stall,
  output tbw_pkg::out_t out_data
);
  import tbw_pkg::*;

  localparam int ROW_WORDS = (MAX_SRC_WIDTH + 31) / 32;
  localparam int DEPTH = ROW_WORDS * MAX_SRC_HEIGHT;
  localparam int AW = $clog2(DEPTH);

  logic [SIZE_W-1:0]  src_width, src_height;
  logic [DSIZE_W-1:0] dst_width, dst_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= clamp9(9'd256, 13'(MAX_SRC_WIDTH));
      src_height <= clamp9(9'd256, 13'(MAX_SRC_HEIGHT));
      dst_width  <= clamp7(7'd64, 7'(MAX_DST_WIDTH));
      dst_height <= clamp7(7'd64, 7'(MAX_DST_HEIGHT));
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SRC_WIDTH:  src_width  <= clamp9(cfg_data, 13'(MAX_SRC_WIDTH));
        CFG_SRC_HEIGHT: src_height <= clamp9(cfg_data, 13'(MAX_SRC_HEIGHT));
        CFG_DST_WIDTH:  dst_width  <= clamp7(cfg_data[6:0], 7'(MAX_DST_WIDTH));
        CFG_DST_HEIGHT: dst_height <= clamp7(cfg_data[6:0], 7'(MAX_DST_HEIGHT));
        default: ;
      endcase
    end
  end

  logic [4:0] words_per_row;
  assign words_per_row = 5'(({1'b0, src_width} + 10'd31) >> 5);

  // Offset reduction
  logic [15:0] mag_x, mag_y;
  logic        neg_x, neg_y;
  logic [SIZE_W-1:0] rem_x, rem_y;
  logic [SIZE_W:0]   tx, ty;

  assign tx = {rem_x, mag_x[15]};
  assign ty = {rem_y, mag_y[15]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_x <= in_data.pos_x[15];
      neg_y <= in_data.pos_y[15];
      mag_x <= in_data.pos_x[15] ? 16'(-in_data.pos_x) : in_data.pos_x;
      mag_y <= in_data.pos_y[15] ? 16'(-in_data.pos_y) : in_data.pos_y;
      rem_x <= '0;
      rem_y <= '0;
    end else if (cmd.mod_step) begin
      mag_x <= mag_x << 1;
      mag_y <= mag_y << 1;
      rem_x <= (tx >= {1'b0, src_width}) ? SIZE_W'(tx - {1'b0, src_width}) : SIZE_W'(tx);
      rem_y <= (ty >= {1'b0, src_height}) ? SIZE_W'(ty - {1'b0, src_height}) : SIZE_W'(ty);
    end else if (cmd.fix) begin
      if (neg_x && rem_x != '0) rem_x <= src_width - rem_x;
      if (neg_y && rem_y != '0) rem_y <= src_height - rem_y;
    end
  end

  // Row assembly
  logic [SIZE_W-1:0]  ys, xs;
  logic [DSIZE_W-1:0] xd, row;
  logic [AW-1:0]      row_base, raddr;
  logic [63:0]        accum;
  logic [31:0]        rdata, shifted, masked;
  logic [4:0]         off;
  logic [5:0]         avail_w, n;
  logic [SIZE_W-1:0]  avail_s, xs_sum;
  logic [DSIZE_W-1:0] xd_sum;
  logic [12:0]        prod;
  logic [63:0]        wmask;

  assign off = xs[4:0];
  assign avail_w = 6'd32 - {1'b0, off};
  assign avail_s = src_width - xs;
  assign n = (avail_s < {3'b0, avail_w}) ? avail_s[5:0] : avail_w;
  assign shifted = rdata >> off;
  assign masked = shifted & (32'hFFFF_FFFF >> (6'd32 - n));
  assign xd_sum = xd + {1'b0, n};
  assign xs_sum = xs + {3'b0, n};
  assign prod = ys * words_per_row;
  assign raddr = row_base + AW'(xs[8:5]);
  assign wmask = dst_width[6] ? '1 : ((64'd1 << dst_width[5:0]) - 64'd1);

  assign sts.row_done = (xd_sum >= dst_width);
  assign sts.last_row = (row + 7'd1 == dst_height);
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.fix) begin
      row <= '0;
    end else if (cmd.emit) begin
      row <= row + 7'd1;
    end
    if (cmd.fix) begin
      ys <= (neg_y && rem_y != '0) ? src_height - rem_y : rem_y;
    end else if (cmd.emit) begin
      ys <= (ys + 9'd1 == src_height) ? '0 : ys + 9'd1;
    end
    if (cmd.row_init) begin
      row_base <= AW'(prod);
      xs <= rem_x;
      xd <= '0;
      accum <= '0;
    end else if (cmd.merge) begin
      accum <= accum | ({32'b0, masked} << xd[5:0]);
      xd <= xd_sum;
      xs <= (xs_sum == src_width) ? '0 : xs_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.row_index <= row[5:0];
      out_data.row_bits <= accum & wmask;
      out_data.last <= sts.last_row;
    end
  end

  logic wr_en;
  assign wr_en = cmd.wr && ({21'b0, in_data.word_index} < 32'(DEPTH));

  tbw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_data.word_index)),
    .wdata (in_data.word_data),
    .re    (cmd.rd),
    .raddr (raddr),
    .rdata (rdata)
  );

`ifndef SYNTHESIS
  a_xs_range: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> xs < src_width)
    else $error("source column out of range");
  a_xd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> xd < dst_width)
    else $error("window column out of range");
  a_ys_range: assert property (@(posedge clk) disable iff (rst)
    cmd.row_init |-> ys < src_height)
    else $error("source row out of range");
`endif
endmodule

// File: tb/tb_toroidal_bitmap_window_extract.sv
// Testbench for the toroidal bitmap window extractor: directed table, then random phases.
`timescale 1ns / 1ps
module tb_toroidal_bitmap_window_extract;
  import tbw_pkg::*;

  localparam int LIMIT = 20000000;
  localparam int DEPTH = 2048;
  localparam int IN_W = $bits(in_t);
  localparam logic [1:0] K_CFG = 2'd0;
  localparam logic [1:0] K_WRITE = 2'd1;
  localparam logic [1:0] K_EXTRACT = 2'd2;

  typedef struct {
    logic [1:0]  kind;
    logic [10:0] addr;
    logic [31:0] val;
    logic [15:0] px;
    logic [15:0] py;
    bit          typed;
    logic [63:0] bits;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;

  bit [31:0] src_mem [DEPTH];
  bit        src_written [DEPTH];
  int unsigned src_w = 256, src_h = 256, win_w = 64, win_h = 64;
  out_t rows_due[$];
  int errors = 0;
  int cycles = 0;
  int send_gap_pct = 0, recv_stall_pct = 0;
  step_t steps[$];

  toroidal_bitmap_window_extract dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (rows_due.size() == 0) begin
        report($sformatf("unexpected row beat %h", out_data));
      end else begin
        want = rows_due.pop_front();
        if (out_data.row_index !== want.row_index)
          report($sformatf("row_index %0d, want %0d", out_data.row_index, want.row_index));
        if (out_data.row_bits !== want.row_bits)
          report($sformatf("row %0d bits %h, want %h", want.row_index, out_data.row_bits,
                           want.row_bits));
        if (out_data.last !== want.last)
          report($sformatf("row %0d last %b, want %b", want.row_index, out_data.last,
                           want.last));
      end
    end
  end

  function automatic int unsigned wrap(input int a, input int unsigned m);
    int r;
    r = a % int'(m);
    if (r < 0) r += int'(m);
    return r;
  endfunction

  function automatic int unsigned size_clamp(input int unsigned v, input int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int unsigned word_addr(input int r, input int xd, input int px, input int py);
    return wrap(r + py, src_h) * ((src_w + 31) / 32) + (wrap(xd + px, src_w) >> 5);
  endfunction

  function automatic void predict_window(input in_t it);
    out_t row;
    int unsigned xs, a;
    for (int r = 0; r < int'(win_h); r++) begin
      row = '0;
      row.row_index = r[5:0];
      row.last = (r + 1 == int'(win_h));
      for (int xd = 0; xd < int'(win_w); xd++) begin
        xs = wrap(xd + int'(it.pos_x), src_w);
        a = word_addr(r, xd, int'(it.pos_x), int'(it.pos_y));
        row.row_bits[xd] = src_mem[a][xs & 31];
      end
      rows_due.push_back(row);
    end
  endfunction

  task automatic send(input in_t it, input bit typed, input logic [63:0] bits);
    while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (it.action == ACT_WRITE) begin
      src_mem[it.word_index] = it.word_data;
      src_written[it.word_index] = 1'b1;
    end else if (typed) begin
      rows_due.push_back('{row_index: 6'd0, row_bits: bits, last: 1'b1});
    end else begin
      predict_window(it);
    end
  endtask

  task automatic store_word(input logic [10:0] a, input logic [31:0] d);
    in_t it;
    it = in_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.action = ACT_WRITE;
    it.word_index = a;
    it.word_data = d;
    send(it, 1'b0, '0);
  endtask

  // fill every source word the window touches that has not been written yet
  task automatic cover_window(input int px, input int py);
    int unsigned a;
    for (int r = 0; r < int'(win_h); r++)
      for (int xd = 0; xd < int'(win_w); xd++) begin
        a = word_addr(r, xd, px, py);
        if (!src_written[a]) store_word(a[10:0], $urandom);
      end
  endtask

  task automatic extract(input logic [15:0] px, input logic [15:0] py, input bit typed,
                         input logic [63:0] bits);
    in_t it;
    it = in_t'(IN_W'({$urandom, $urandom, $urandom}));
    it.action = ACT_EXTRACT;
    it.pos_x = px;
    it.pos_y = py;
    cover_window($signed(px), $signed(py));
    send(it, typed, bits);
  endtask

  task automatic set_reg(input logic [1:0] idx, input logic [8:0] v);
    in_valid <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  src_w = size_clamp({23'b0, v}, 256);
      CFG_SRC_HEIGHT: src_h = size_clamp({23'b0, v}, 256);
      CFG_DST_WIDTH:  win_w = size_clamp({25'b0, v[6:0]}, 64);
      CFG_DST_HEIGHT: win_h = size_clamp({25'b0, v[6:0]}, 64);
      default: ;
    endcase
  endtask

  function automatic void add(input logic [1:0] k, input logic [10:0] a, input logic [31:0] d,
                              input logic [15:0] px, input logic [15:0] py, input bit typed,
                              input logic [63:0] bits);
    steps.push_back('{k, a, d, px, py, typed, bits});
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [8:0] v);
    steps.push_back('{K_CFG, {9'b0, idx}, {23'b0, v}, 16'h0, 16'h0, 1'b0, 64'h0});
  endfunction

  initial begin
    step_t s;
    int r;
    // one-bit source, one-row window, full-width window
    add_cfg(CFG_SRC_WIDTH, 9'd0);
    add_cfg(CFG_SRC_HEIGHT, 9'd0);
    add_cfg(CFG_DST_WIDTH, 9'd127);
    add_cfg(CFG_DST_HEIGHT, 9'd0);
    add(K_WRITE, 11'd0, 32'h0000_0001, 16'h1234, 16'h8765, 0, 0);
    add(K_EXTRACT, 11'h7ff, 32'hffff_ffff, 16'h0000, 16'h0000, 1, 64'hffff_ffff_ffff_ffff);
    add(K_EXTRACT, 11'h7ff, 32'h0, 16'h8000, 16'h7fff, 1, 64'hffff_ffff_ffff_ffff);
    add(K_WRITE, 11'd0, 32'hffff_fffe, 16'hffff, 16'hffff, 0, 0);
    add(K_EXTRACT, 11'h0, 32'h0, 16'h7fff, 16'h8000, 1, 64'h0);
    // saturated sources
    add_cfg(CFG_SRC_WIDTH, 9'd511);
    add_cfg(CFG_SRC_HEIGHT, 9'd511);
    add_cfg(CFG_DST_HEIGHT, 9'd3);
    add(K_WRITE, 11'h7ff, 32'hffff_ffff, 0, 0, 0, 0);
    add(K_WRITE, 11'h000, 32'h0000_0000, 0, 0, 0, 0);
    add(K_EXTRACT, 0, 0, 16'h8000, 16'h8000, 0, 0);
    add(K_EXTRACT, 0, 0, 16'h7fff, 16'h7fff, 0, 0);
    add(K_EXTRACT, 0, 0, 16'hffe1, 16'hffff, 0, 0);
    // odd sizes, wrap in both axes
    add_cfg(CFG_SRC_WIDTH, 9'd37);
    add_cfg(CFG_SRC_HEIGHT, 9'd5);
    add_cfg(CFG_DST_WIDTH, 9'd1);
    add_cfg(CFG_DST_HEIGHT, 9'd127);
    add(K_EXTRACT, 0, 0, 16'hfffb, 16'h0003, 0, 0);
    add_cfg(CFG_DST_WIDTH, 9'd64);
    add_cfg(CFG_DST_HEIGHT, 9'd7);
    add(K_EXTRACT, 0, 0, 16'h0025, 16'hfff6, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i]) begin
      s = steps[i];
      case (s.kind)
        K_CFG:   set_reg(s.addr[1:0], s.val[8:0]);
        K_WRITE: store_word(s.addr, s.val);
        default: extract(s.px, s.py, s.typed, s.bits);
      endcase
    end

    for (int ph = 0; ph < 8; ph++) begin
      set_reg(CFG_SRC_WIDTH, ($urandom_range(3) == 0) ? 9'd256 : 9'($urandom_range(511)));
      set_reg(CFG_SRC_HEIGHT, ($urandom_range(3) == 0) ? 9'd0 : 9'($urandom_range(16, 1)));
      set_reg(CFG_DST_WIDTH, ($urandom_range(7) == 0) ? 9'd64 : 9'($urandom_range(24)));
      set_reg(CFG_DST_HEIGHT, ($urandom_range(7) == 0) ? 9'd64 : 9'($urandom_range(8)));
      case (ph % 4)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 81; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 81; end
        default: begin send_gap_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int n = 0; n < 20; n++) begin
        r = $urandom_range(9);
        if (r < 6) extract(16'($urandom), 16'($urandom), 1'b0, '0);
        else store_word(11'($urandom_range(DEPTH - 1)), $urandom);
      end
    end

    in_valid <= 1'b0;
    send_gap_pct = 0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// File: sim.f
rtl/tbw_pkg.sv
rtl/tbw_ram.sv
rtl/tbw_ctrl.sv
rtl/tbw_dp.sv
rtl/toroidal_bitmap_window_extract.sv
tb/tb_toroidal_bitmap_window_extract.sv
